### rtl/mnva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mnva_pkg;

  // Field widths of the stream words, the configuration register and the frequency datapath.
  localparam int RX_W       = 8;
  localparam int FREQ_W     = 16;
  localparam int VOICE_W    = 2;
  localparam int CFG_W      = 3;
  localparam int OUT_DATA_W = 24;
  localparam int BASE_W     = 13;
  localparam int SHIFTED_W  = 24;
  localparam int PROD_W     = 48;

  // MIDI codes.
  localparam logic [RX_W-1:0] STOP_BYTE   = 8'hFC;
  localparam logic [3:0]      KIND_OFF    = 4'h8;
  localparam logic [3:0]      KIND_ON     = 4'h9;
  localparam logic [RX_W-1:0] LOWEST_NOTE = 8'd21;

  // Octave split: octave = (rel * 171) >> 11 is exact for rel below 512.
  localparam logic [7:0] OCT_RECIP = 8'd171;
  localparam int         OCT_SHIFT = 11;
  localparam logic [4:0] OCT_SAT   = 5'd12;

  // Division by 100: q = (v * ceil(2^30 / 100)) >> 30, exact for v below 2^23.
  localparam logic [SHIFTED_W-1:0] DIV_RECIP = 24'd10737419;
  localparam int                   DIV_SHIFT = 30;
  // Smallest shifted value whose quotient no longer fits in 16 bits.
  localparam logic [SHIFTED_W-1:0] SAT_LIMIT = 24'd6553600;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_BUILD,
    ST_WALK
  } state_e;

  // What an incoming byte sets off.
  typedef enum logic [1:0] {
    BYTE_NONE,
    BYTE_STOP,
    BYTE_NOTE
  } byte_act_e;

  // Voice operation for the current walk.
  typedef enum logic [1:0] {
    OP_STOP,
    OP_RELEASE,
    OP_START
  } op_e;

  typedef struct packed {
    logic take;
    logic build;
    logic emit;
  } cmd_t;

  typedef struct packed {
    byte_act_e byte_act;
    logic      act_empty;
    logic      out_free;
  } status_t;

  // Base tone of each semitone from A0 to G#1 in hundredths of a hertz.
  function automatic logic [BASE_W-1:0] base_centihz(input logic [3:0] semi);
    logic [BASE_W-1:0] r;
    unique case (semi)
      4'd0:    r = 13'd2750;
      4'd1:    r = 13'd2914;
      4'd2:    r = 13'd3087;
      4'd3:    r = 13'd3270;
      4'd4:    r = 13'd3464;
      4'd5:    r = 13'd3671;
      4'd6:    r = 13'd3889;
      4'd7:    r = 13'd4120;
      4'd8:    r = 13'd4365;
      4'd9:    r = 13'd4625;
      4'd10:   r = 13'd4900;
      4'd11:   r = 13'd5191;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mnva_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mnva_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mnva_pkg::status_t  status_i,
  output mnva_pkg::cmd_t          cmd_o
);

  mnva_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnva_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mnva_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.byte_act)
            mnva_pkg::BYTE_STOP: state_d = mnva_pkg::ST_BUILD;
            mnva_pkg::BYTE_NOTE: state_d = mnva_pkg::ST_CALC1;
            default:             state_d = mnva_pkg::ST_IDLE;
          endcase
        end
      end
      mnva_pkg::ST_CALC1: state_d = mnva_pkg::ST_CALC2;
      mnva_pkg::ST_CALC2: state_d = mnva_pkg::ST_BUILD;
      mnva_pkg::ST_BUILD: state_d = mnva_pkg::ST_WALK;
      mnva_pkg::ST_WALK: begin
        if (status_i.act_empty) begin
          state_d = mnva_pkg::ST_IDLE;
        end
      end
      default: state_d = mnva_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o  = (state_q == mnva_pkg::ST_IDLE);
    cmd_o.take  = (state_q == mnva_pkg::ST_IDLE) && in_valid_i;
    cmd_o.build = (state_q == mnva_pkg::ST_BUILD);
    cmd_o.emit  = (state_q == mnva_pkg::ST_WALK) && !status_i.act_empty && status_i.out_free;
  end

endmodule

`default_nettype wire

### rtl/mnva_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mnva_dp #(
  parameter int VOICES = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mnva_pkg::cmd_t                  cmd_i,
  output mnva_pkg::status_t                    status_o,
  input  wire logic [mnva_pkg::RX_W-1:0]       rx_byte_i,
  input  wire logic                            cfg_wr_en_i,
  input  wire logic [mnva_pkg::CFG_W-1:0]      cfg_wr_data_i,
  output logic      [mnva_pkg::VOICE_W-1:0]    voice_o,
  output logic      [mnva_pkg::FREQ_W-1:0]     frequency_o,
  output logic                                 last_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Configuration and message parser state.
  logic [mnva_pkg::CFG_W-1:0] voices_q;
  logic                       collecting_q;
  logic                       note_idx_q;
  logic                       is_on_q;
  logic [mnva_pkg::RX_W-1:0]  held_note_q;
  mnva_pkg::op_e              op_q;

  // Frequency pipeline.
  logic [mnva_pkg::RX_W-1:0]      rel;
  logic [15:0]                    oct_mul;
  logic [mnva_pkg::RX_W-1:0]      rel_q;
  logic [4:0]                     oct_q;
  logic [mnva_pkg::RX_W-1:0]      oct12;
  logic [mnva_pkg::RX_W-1:0]      semi;
  logic [mnva_pkg::SHIFTED_W-1:0] shifted;
  logic [mnva_pkg::SHIFTED_W-1:0] shifted_q;
  logic                           sat_oct_q;
  logic [mnva_pkg::PROD_W-1:0]    prod_q;
  logic                           sat_q;
  logic [mnva_pkg::FREQ_W-1:0]    note_freq;

  // Voice bank and walk.
  logic [mnva_pkg::FREQ_W-1:0] vf_q [VOICES];
  logic [VOICES-1:0]           free_q;
  logic [VOICES-1:0]           act_q;
  logic [mnva_pkg::FREQ_W-1:0] f_q;
  logic [VOICES-1:0]           lim_mask;
  logic [VOICES-1:0]           match;
  logic [VOICES-1:0]           avail;
  logic [VOICES-1:0]           first_free;
  logic [VOICES-1:0]           act_build;
  logic [VOICES-1:0]           act_rest;
  logic [IW-1:0]               sel_idx;
  logic [mnva_pkg::FREQ_W-1:0] upd_freq;

  // Output register.
  logic                           out_valid_q;
  logic [mnva_pkg::VOICE_W-1:0]   voice_q;
  logic [mnva_pkg::FREQ_W-1:0]    freq_q;
  logic                           last_q;

  // Voice count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voices_q <= mnva_pkg::CFG_RESET;
    end else if (cfg_wr_en_i) begin
      voices_q <= cfg_wr_data_i;
    end
  end

  // Classify the byte on the input for the controller.
  always_comb begin
    if (!collecting_q) begin
      status_o.byte_act = (rx_byte_i == mnva_pkg::STOP_BYTE) ? mnva_pkg::BYTE_STOP
                                                              : mnva_pkg::BYTE_NONE;
    end else if (note_idx_q && (held_note_q >= mnva_pkg::LOWEST_NOTE)) begin
      status_o.byte_act = mnva_pkg::BYTE_NOTE;
    end else begin
      status_o.byte_act = mnva_pkg::BYTE_NONE;
    end
    status_o.act_empty = (act_q == '0);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Message parser: status byte, note byte, then velocity byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      note_idx_q   <= 1'b0;
      is_on_q      <= 1'b0;
      held_note_q  <= '0;
      op_q         <= mnva_pkg::OP_STOP;
    end else if (cmd_i.take) begin
      if (!collecting_q) begin
        if ((rx_byte_i[7:4] == mnva_pkg::KIND_OFF) || (rx_byte_i[7:4] == mnva_pkg::KIND_ON)) begin
          collecting_q <= 1'b1;
          note_idx_q   <= 1'b0;
          is_on_q      <= (rx_byte_i[7:4] == mnva_pkg::KIND_ON);
        end
        if (rx_byte_i == mnva_pkg::STOP_BYTE) begin
          op_q <= mnva_pkg::OP_STOP;
        end
      end else if (!note_idx_q) begin
        held_note_q <= rx_byte_i;
        note_idx_q  <= 1'b1;
      end else begin
        collecting_q <= 1'b0;
        note_idx_q   <= 1'b0;
        op_q         <= (is_on_q && (rx_byte_i != '0)) ? mnva_pkg::OP_START
                                                       : mnva_pkg::OP_RELEASE;
      end
    end
  end

  // Frequency stage one: semitones above A0 and the octave.
  always_comb begin
    rel     = held_note_q - mnva_pkg::LOWEST_NOTE;
    oct_mul = 16'(rel) * 16'(mnva_pkg::OCT_RECIP);
  end

  always_ff @(posedge clk_i) begin
    rel_q <= rel;
    oct_q <= oct_mul[mnva_pkg::OCT_SHIFT +: 5];
  end

  // Frequency stage two: semitone within the octave and the shifted base tone.
  always_comb begin
    oct12   = 8'({oct_q, 3'b000}) + 8'({oct_q, 2'b00});
    semi    = rel_q - oct12;
    shifted = mnva_pkg::SHIFTED_W'(mnva_pkg::base_centihz(semi[3:0])) << oct_q[3:0];
  end

  always_ff @(posedge clk_i) begin
    shifted_q <= shifted;
    sat_oct_q <= (oct_q >= mnva_pkg::OCT_SAT);
  end

  // Frequency stage three: divide by one hundred and saturate.
  always_ff @(posedge clk_i) begin
    prod_q <= mnva_pkg::PROD_W'(shifted_q) * mnva_pkg::PROD_W'(mnva_pkg::DIV_RECIP);
    sat_q  <= sat_oct_q || (shifted_q >= mnva_pkg::SAT_LIMIT);
  end

  assign note_freq = sat_q ? '1 : prod_q[mnva_pkg::DIV_SHIFT +: mnva_pkg::FREQ_W];

  // Per-voice compares for building the set of voices to command.
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      lim_mask[i] = (5'(i) < {2'b00, voices_q});
      match[i]    = (vf_q[i] == note_freq);
    end
    avail      = free_q & lim_mask;
    first_free = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (avail[i]) begin
        first_free    = '0;
        first_free[i] = 1'b1;
      end
    end
    unique case (op_q)
      mnva_pkg::OP_STOP:    act_build = lim_mask;
      mnva_pkg::OP_RELEASE: act_build = match & lim_mask;
      mnva_pkg::OP_START:   act_build = (|(match & lim_mask)) ? '0 : first_free;
      default:              act_build = '0;
    endcase
  end

  // Lowest voice still to be commanded.
  always_comb begin
    sel_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (act_q[i]) begin
        sel_idx = IW'(i);
      end
    end
    act_rest          = act_q;
    act_rest[sel_idx] = 1'b0;
    upd_freq          = (op_q == mnva_pkg::OP_START) ? f_q : '0;
  end

  // Walk set and held note frequency.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else if (cmd_i.build) begin
      act_q <= act_build;
    end else if (cmd_i.emit) begin
      act_q <= act_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build) begin
      f_q <= note_freq;
    end
  end

  // Voice bank update, one voice per command word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        vf_q[i] <= '0;
      end
      free_q <= '1;
    end else if (cmd_i.emit) begin
      vf_q[sel_idx]   <= upd_freq;
      free_q[sel_idx] <= (op_q != mnva_pkg::OP_START);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      voice_q <= mnva_pkg::VOICE_W'(sel_idx);
      freq_q  <= upd_freq;
      last_q  <= (act_rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign voice_o     = voice_q;
  assign frequency_o = freq_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### rtl/midi_note_voice_allocator.sv
// A note message's final byte for a note at or above LOWEST_NOTE moves the controller
// through ST_CALC1, ST_CALC2 and ST_BUILD, a stop byte straight to ST_BUILD; ST_WALK
// then issues the words (at most VOICES) through the output register, back to back
// unless the output stalls. The input stays not ready from either byte until the walk
// has issued its last word; any other byte is taken without holding the input.
// Reset (rst_ni low, asynchronous) frees all voices, zeroes them and sets the count to 4.
`timescale 1ns / 1ps
`default_nettype none

module midi_note_voice_allocator #(
  parameter int VOICES = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: rx_byte[7:0]
  input  wire logic [mnva_pkg::RX_W-1:0]           s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: voice[1:0], frequency[17:2], zero padding[23:18]
  output logic      [mnva_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                     m_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_wr_en_i,
  input  wire logic [mnva_pkg::CFG_W-1:0]          cfg_wr_data_i
);

  mnva_pkg::cmd_t               cmd;
  mnva_pkg::status_t            status;
  logic [mnva_pkg::VOICE_W-1:0] voice;
  logic [mnva_pkg::FREQ_W-1:0]  frequency;

  // Sequencer.
  mnva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Parser, frequency pipeline, voice bank and output register.
  mnva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .rx_byte_i     (s_axis_tdata),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .voice_o       (voice),
    .frequency_o   (frequency),
    .last_o        (m_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready)
  );

  // Pack the result word.
  assign m_axis_tdata = mnva_pkg::OUT_DATA_W'({frequency, voice});

endmodule

`default_nettype wire

### rtl/mnva_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module mnva_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready
);

  // A stalled result word holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  else $error("result word changed while stalled");

  // The padding above the frequency field is always zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:18] == 6'd0))
  else $error("result padding bits not zero");

  // A new result only appears while the input side is busy with a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !s_axis_tready)
  else $error("result appeared while input was ready");

  // No result can follow an accepted byte in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
  else $error("result appeared one cycle after a byte");

endmodule

bind midi_note_voice_allocator mnva_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

### sim/midi_note_voice_allocator_test.sv
`timescale 1ns / 1ps

module midi_note_voice_allocator_test;

  localparam int VOICES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  // Base tones A0 .. G#1 in hundredths of a hertz, semitone 0 in the lowest slice.
  localparam logic [12*16-1:0] SEMI_TABLE = {
    16'd5191, 16'd4900, 16'd4625, 16'd4365, 16'd4120, 16'd3889,
    16'd3671, 16'd3464, 16'd3270, 16'd3087, 16'd2914, 16'd2750
  };

  typedef struct packed {
    logic [mnva_pkg::VOICE_W-1:0] voice;
    logic [mnva_pkg::FREQ_W-1:0]  freq;
    logic                         last;
  } voice_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [mnva_pkg::RX_W-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mnva_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic [mnva_pkg::CFG_W-1:0] cfg_wr_data_i = '0;

  // Mirror of the allocator: parser state, voice bank and voice count.
  logic in_message = 1'b0;
  logic have_note = 1'b0;
  logic [3:0] msg_kind = '0;
  logic [mnva_pkg::RX_W-1:0] note_held = '0;
  logic [mnva_pkg::FREQ_W-1:0] tone_hz [VOICES];
  logic tone_free [VOICES];
  logic [mnva_pkg::CFG_W-1:0] voice_count = mnva_pkg::CFG_RESET;

  voice_cmd_t voice_cmds[$];
  int errors = 0;
  int bytes_sent = 0;
  bit no_idle = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  logic [mnva_pkg::RX_W-1:0] note_pool [6];

  midi_note_voice_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly none, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Whole-hertz tone of a note at or above the lowest playable one.
  function automatic logic [mnva_pkg::FREQ_W-1:0] note_to_hz(
      input logic [mnva_pkg::RX_W-1:0] note);
    int unsigned rel;
    logic [63:0] scaled;
    rel = note - mnva_pkg::LOWEST_NOTE;
    scaled = (64'(SEMI_TABLE[16*(rel % 12) +: 16]) << (rel / 12)) / 100;
    return (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
  endfunction

  task automatic queue_cmd(input int v, input logic [mnva_pkg::FREQ_W-1:0] hz);
    voice_cmd_t cmd;
    cmd.voice = v[mnva_pkg::VOICE_W-1:0];
    cmd.freq = hz;
    cmd.last = 1'b0;
    voice_cmds.push_back(cmd);
  endtask

  // Advance the mirror by one accepted byte and queue the voice words it causes.
  task automatic track_midi_byte(input logic [mnva_pkg::RX_W-1:0] b);
    int start_len;
    int lim;
    logic [mnva_pkg::FREQ_W-1:0] hz;
    bit playing;
    bit placed;
    start_len = voice_cmds.size();
    lim = (voice_count > VOICES) ? VOICES : int'(voice_count);
    if (!in_message) begin
      if (b == mnva_pkg::STOP_BYTE) begin
        for (int i = 0; i < lim; i++) begin
          tone_hz[i] = '0;
          tone_free[i] = 1'b1;
          queue_cmd(i, '0);
        end
      end else if (b[7:4] == mnva_pkg::KIND_OFF || b[7:4] == mnva_pkg::KIND_ON) begin
        in_message = 1'b1;
        have_note = 1'b0;
        msg_kind = b[7:4];
      end
    end else if (!have_note) begin
      note_held = b;
      have_note = 1'b1;
    end else begin
      in_message = 1'b0;
      have_note = 1'b0;
      if (note_held >= mnva_pkg::LOWEST_NOTE) begin
        hz = note_to_hz(note_held);
        if (msg_kind == mnva_pkg::KIND_ON && b != 0) begin
          // A tone already sounding is not doubled; otherwise the first free voice takes it.
          playing = 1'b0;
          placed = 1'b0;
          for (int i = 0; i < lim; i++) begin
            if (tone_hz[i] == hz) playing = 1'b1;
          end
          for (int i = 0; i < lim; i++) begin
            if (!playing && !placed && tone_free[i]) begin
              tone_hz[i] = hz;
              tone_free[i] = 1'b0;
              queue_cmd(i, hz);
              placed = 1'b1;
            end
          end
        end else begin
          for (int i = 0; i < lim; i++) begin
            if (tone_hz[i] == hz) begin
              tone_hz[i] = '0;
              tone_free[i] = 1'b1;
              queue_cmd(i, '0);
            end
          end
        end
      end
    end
    if (voice_cmds.size() > start_len) voice_cmds[voice_cmds.size()-1].last = 1'b1;
  endtask

  // Offer one byte and wait for its handshake; valid stays high for a back-to-back byte.
  task automatic send_byte(input logic [mnva_pkg::RX_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= b;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_midi_byte(b);
    bytes_sent++;
  endtask

  task automatic send_note_msg(input logic [3:0] kind, input logic [3:0] chan,
                               input logic [mnva_pkg::RX_W-1:0] note,
                               input logic [mnva_pkg::RX_W-1:0] vel);
    send_byte({kind, chan});
    send_byte(note);
    send_byte(vel);
  endtask

  // Stop offering, let every expected word arrive, then let the block settle.
  task automatic wait_for_silence();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (voice_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_voice_count(input logic [mnva_pkg::CFG_W-1:0] n);
    wait_for_silence();
    cfg_wr_data_i <= n;
    cfg_wr_en_i <= 1'b1;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    voice_count = n;
  endtask

  // Lowest and highest notes, duplicate note-on, low note, velocity-zero release.
  task automatic test_note_extremes();
    send_note_msg(mnva_pkg::KIND_ON, 4'h0, mnva_pkg::LOWEST_NOTE, 8'd127);
    send_note_msg(mnva_pkg::KIND_ON, 4'h5, mnva_pkg::LOWEST_NOTE, 8'd100);
    send_note_msg(mnva_pkg::KIND_ON, 4'hF, 8'd255, 8'd255);
    send_note_msg(mnva_pkg::KIND_ON, 4'h0, mnva_pkg::LOWEST_NOTE - 8'd1, 8'd1);
    send_note_msg(mnva_pkg::KIND_OFF, 4'h0, mnva_pkg::LOWEST_NOTE, 8'd64);
    send_note_msg(mnva_pkg::KIND_ON, 4'h9, 8'd255, 8'd0);
  endtask

  // Bytes ignored while idle, status bytes taken as data, and the stop byte.
  task automatic test_stop_and_ignored();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hA3);
    send_byte(8'hFF);
    send_byte({mnva_pkg::KIND_ON, 4'h3});
    send_byte({mnva_pkg::KIND_ON, 4'h0});
    send_byte(mnva_pkg::STOP_BYTE);
    send_byte(mnva_pkg::STOP_BYTE);
  endtask

  // Voice counts of zero, one, the full bank and above it; voices outside keep their tones.
  task automatic test_voice_count();
    set_voice_count(3'd0);
    send_note_msg(mnva_pkg::KIND_ON, 4'h0, 8'd60, 8'd100);
    send_byte(mnva_pkg::STOP_BYTE);
    set_voice_count(3'd1);
    send_note_msg(mnva_pkg::KIND_ON, 4'h0, 8'd60, 8'd1);
    send_note_msg(mnva_pkg::KIND_ON, 4'h0, 8'd61, 8'd1);
    set_voice_count(3'd4);
    send_note_msg(mnva_pkg::KIND_ON, 4'h0, 8'd62, 8'd1);
    send_note_msg(mnva_pkg::KIND_ON, 4'h0, 8'd63, 8'd1);
    set_voice_count(3'd1);
    send_byte(mnva_pkg::STOP_BYTE);
    set_voice_count(3'd4);
    send_note_msg(mnva_pkg::KIND_OFF, 4'h2, 8'd63, 8'd0);
    set_voice_count(3'd7);
    send_byte(mnva_pkg::STOP_BYTE);
  endtask

  // The receiver holds off for a long stretch while notes and stops keep coming.
  task automatic test_output_backpressure();
    set_voice_count(3'd4);
    no_idle = 1'b1;
    hold_requests++;
    for (int i = 0; i < 4; i++) begin
      send_note_msg(mnva_pkg::KIND_ON, i[3:0], 8'd40 + 8'(i), 8'd90);
    end
    repeat (3) send_byte(mnva_pkg::STOP_BYTE);
    no_idle = 1'b0;
    wait_for_silence();
  endtask

  // Mostly well-formed note messages over a small note pool, plus stops, cut messages, noise.
  task automatic test_random_traffic(input logic [mnva_pkg::CFG_W-1:0] count,
                                     input int n_bytes, input bit calm);
    int target;
    int r;
    logic [3:0] kind;
    logic [mnva_pkg::RX_W-1:0] note;
    logic [mnva_pkg::RX_W-1:0] vel;
    set_voice_count(count);
    no_idle = calm;
    for (int i = 0; i < 5; i++) note_pool[i] = 8'($urandom_range(21, 127));
    note_pool[5] = 8'($urandom_range(180, 255));
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      kind = ($urandom_range(0, 9) < 6) ? mnva_pkg::KIND_ON : mnva_pkg::KIND_OFF;
      note = ($urandom_range(0, 3) != 0) ? note_pool[$urandom_range(0, 5)]
                                         : 8'($urandom_range(0, 255));
      vel = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      if (r < 70) begin
        send_note_msg(kind, 4'($urandom_range(0, 15)), note, vel);
      end else if (r < 80) begin
        send_byte(mnva_pkg::STOP_BYTE);
      end else if (r < 88) begin
        send_byte({kind, 4'($urandom_range(0, 15))});
        send_byte(note);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver readiness: a requested long hold first, then random stalls.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = no_idle ? 0 : pick_gap();
    end
  end

  // Compare each accepted word with the oldest expected voice command.
  always @(posedge clk_i) begin : check_words
    voice_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (voice_cmds.size() == 0) begin
        $error("unexpected word: voice %0d frequency %0d last %0b",
               m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tlast);
        errors++;
      end else begin
        want = voice_cmds.pop_front();
        if (m_axis_tdata[1:0] !== want.voice) begin
          $error("voice: expected %0d, got %0d", want.voice, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[17:2] !== want.freq) begin
          $error("frequency: expected %0d, got %0d", want.freq, m_axis_tdata[17:2]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake or register write.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("midi_note_voice_allocator_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < VOICES; i++) begin
      tone_hz[i] = '0;
      tone_free[i] = 1'b1;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_note_extremes();
    test_stop_and_ignored();
    test_voice_count();
    test_output_backpressure();
    test_random_traffic(3'd4, 35, 1'b0);
    test_random_traffic(3'd2, 20, 1'b0);
    test_random_traffic(3'd7, 15, 1'b1);
    test_random_traffic(3'd1, 12, 1'b0);
    test_random_traffic(3'd3, 15, 1'b0);
    wait_for_silence();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("midi_note_voice_allocator_test: clean");
    end else begin
      $display("midi_note_voice_allocator_test: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mnva_pkg.sv
rtl/mnva_ctrl.sv
rtl/mnva_dp.sv
rtl/midi_note_voice_allocator.sv
rtl/mnva_chk.sv
sim/midi_note_voice_allocator_test.sv
